>>> design/utf8_byte_decoder_assert.svh
// assertion macros for the utf8 byte decoder
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef UTF8_BYTE_DECODER_ASSERT_SVH
`define UTF8_BYTE_DECODER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define UBD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ubd assertion failed");
// next-cycle implication, checked out of reset
`define UBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ubd assertion failed");
`else
`define UBD_ASSERT_IMPL(lbl, ante, cons)
`define UBD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> design/ubd_pkg.sv
// shared types and constants for the utf8 byte decoder
// no dependencies
`timescale 1ns / 1ps

package ubd_pkg;

    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int STAT_W = 2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_VALID   = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_STOP    = 2'd2;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // lead bytes with restricted second-byte ranges
    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_ED = 8'hED;
    localparam logic [7:0] LEAD_F0 = 8'hF0;
    localparam logic [7:0] LEAD_F4 = 8'hF4;

    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] E0_MIN    = 8'hA0;
    localparam logic [7:0] ED_MAX    = 8'h9F;
    localparam logic [7:0] F0_MIN    = 8'h90;
    localparam logic [7:0] F4_MAX    = 8'h8F;

    // code point bits 20:11 of a surrogate (D800..DFFF)
    localparam logic [9:0] SURR_HI = 10'h01B;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] bytes_left;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic [LEN_W-1:0]  seq_length;
        logic [STAT_W-1:0] status;
    } t_result;

    // handshake between the stages
    typedef struct packed {
        logic step;     // input stage item consumed this cycle
        logic load;     // a result goes into the output register
    } t_flow;

endpackage

>>> design/ubd_in_stage.sv
// input register of the utf8 byte decoder
// depends on ubd_pkg
`timescale 1ns / 1ps

module ubd_in_stage
    import ubd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  t_flow    i_flow,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;

    assign o_ready = !r_valid || i_flow.step;
    assign n_valid = (i_valid && o_ready) ? 1'b1 : (i_flow.step ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> design/ubd_core.sv
// sequence state and per-byte decode of the utf8 byte decoder
// depends on ubd_pkg
`timescale 1ns / 1ps

module ubd_core
    import ubd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_item i_item,
    output logic     o_res_valid,
    output t_result  o_res
);

    logic [LEN_W-1:0] r_exp_len;
    logic [LEN_W-1:0] r_byte_idx;
    logic [CP_W-1:0]  r_accum;
    logic             r_seq_bad;
    logic [7:0]       r_lead;

    logic [LEN_W-1:0] n_exp_len;
    logic [LEN_W-1:0] n_byte_idx;
    logic [CP_W-1:0]  n_accum;
    logic             n_seq_bad;
    logic [7:0]       n_lead;

    logic [7:0]       b;
    logic [LEN_W-1:0] left;
    logic [LEN_W-1:0] lead_len;
    logic [CP_W-1:0]  lead_payload;
    logic             second_ok;
    logic [LEN_W-1:0] idx_inc;
    logic [CP_W-1:0]  acc_nx;
    logic             bad_nx;

    assign b    = i_item.data_byte;
    assign left = i_item.bytes_left;

    // lead byte class
    always_comb begin
        lead_len     = 3'd0;
        lead_payload = '0;
        unique casez (b)
            8'b0???????: begin
                lead_len     = 3'd1;
                lead_payload = {13'd0, b};
            end
            8'b110?????: begin
                lead_len     = 3'd2;
                lead_payload = {16'd0, b[4:0]};
            end
            8'b1110????: begin
                lead_len     = 3'd3;
                lead_payload = {17'd0, b[3:0]};
            end
            8'b11110???: begin
                lead_len     = 3'd4;
                lead_payload = {18'd0, b[2:0]};
            end
            default: begin
                lead_len     = 3'd0;
                lead_payload = '0;
            end
        endcase
    end

    // second byte range after special leads
    always_comb begin
        case (r_lead)
            LEAD_E0: second_ok = (b >= E0_MIN) && (b <= CONT_MAX);
            LEAD_ED: second_ok = (b <= ED_MAX);
            LEAD_F0: second_ok = (b >= F0_MIN) && (b <= CONT_MAX);
            LEAD_F4: second_ok = (b <= F4_MAX);
            default: second_ok = 1'b1;
        endcase
    end

    // continuation byte: check, then shift in six payload bits
    always_comb begin
        bad_nx = r_seq_bad;
        acc_nx = r_accum;
        if (!r_seq_bad) begin
            if ((r_byte_idx == 3'd1) && !second_ok) begin
                bad_nx = 1'b1;
            end else if (b[7:6] != 2'b10) begin
                bad_nx = 1'b1;
            end else begin
                acc_nx = {r_accum[CP_W-7:0], b[5:0]};
            end
        end
    end

    assign idx_inc = r_byte_idx + 3'd1;

    always_comb begin
        n_exp_len   = r_exp_len;
        n_byte_idx  = r_byte_idx;
        n_accum     = r_accum;
        n_seq_bad   = r_seq_bad;
        n_lead      = r_lead;
        o_res_valid = 1'b0;
        o_res       = '{code_point: '0, seq_length: '0, status: ST_STOP};
        if (r_exp_len == 3'd0) begin
            // idle: this is a lead byte
            if ((b == 8'd0) || (left == 3'd0) || (lead_len == 3'd0)) begin
                o_res_valid = 1'b1;
            end else if (lead_len == 3'd1) begin
                o_res_valid = 1'b1;
                o_res       = '{code_point: lead_payload, seq_length: 3'd1,
                                status: ST_VALID};
            end else if (left < lead_len) begin
                o_res_valid = 1'b1;
                o_res       = '{code_point: REPLACEMENT_CP, seq_length: 3'd1,
                                status: ST_INVALID};
            end else begin
                n_exp_len  = lead_len;
                n_byte_idx = 3'd1;
                n_accum    = lead_payload;
                n_lead     = b;
                n_seq_bad  = ((lead_len == 3'd2) && (b < LEAD2_MIN)) ||
                             ((lead_len == 3'd4) && (b > LEAD4_MAX));
            end
        end else if (idx_inc >= r_exp_len) begin
            // last byte of the sequence
            o_res_valid = 1'b1;
            if (bad_nx || (acc_nx[CP_W-1:11] == SURR_HI)) begin
                o_res = '{code_point: REPLACEMENT_CP, seq_length: r_exp_len,
                          status: ST_INVALID};
            end else begin
                o_res = '{code_point: acc_nx, seq_length: r_exp_len,
                          status: ST_VALID};
            end
            n_exp_len  = 3'd0;
            n_byte_idx = 3'd0;
            n_accum    = '0;
            n_seq_bad  = 1'b0;
            n_lead     = 8'd0;
        end else begin
            n_byte_idx = idx_inc;
            n_accum    = acc_nx;
            n_seq_bad  = bad_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len  <= 3'd0;
            r_byte_idx <= 3'd0;
            r_accum    <= '0;
            r_seq_bad  <= 1'b0;
            r_lead     <= 8'd0;
        end else if (i_step) begin
            r_exp_len  <= n_exp_len;
            r_byte_idx <= n_byte_idx;
            r_accum    <= n_accum;
            r_seq_bad  <= n_seq_bad;
            r_lead     <= n_lead;
        end
    end

endmodule

>>> design/ubd_out_stage.sv
// result register of the utf8 byte decoder
// depends on ubd_pkg
`timescale 1ns / 1ps

module ubd_out_stage
    import ubd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_flow   i_flow,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;
    logic    n_valid;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_flow.load ? 1'b1 : (i_ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> design/utf8_byte_decoder.sv
// a byte is taken into the input register and decoded there; its result (if any) is loaded into the result register
// throughput: one byte per cycle sustained; set by the input and result registers
//   around the single decode step, which stalls only while the result register is held
// bytes in the middle of a sequence give no result and never wait on m_tready
// reset: synchronous, active low; clears both stage valids and the sequence state (idle)
`timescale 1ns / 1ps
`include "utf8_byte_decoder_assert.svh"

module utf8_byte_decoder
    import ubd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [10:8] bytes_left, [15:11] zero
    // code point stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] seq_length
    output logic [1:0]  m_tuser    // [1:0] status
);

    t_in_item w_in_item;
    t_in_item w_cur_item;
    logic     w_cur_valid;
    logic     w_res_valid;
    t_result  w_res;
    t_result  w_out_res;
    logic     w_out_free;
    t_flow    w_flow;

    // unpack the request
    assign w_in_item = '{data_byte: s_tdata[7:0], bytes_left: s_tdata[10:8]};

    // the held byte advances unless it makes a result that has nowhere to go
    assign w_flow.step = w_cur_valid && (!w_res_valid || w_out_free);
    assign w_flow.load = w_flow.step && w_res_valid;

    ubd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_item  (w_in_item),
        .i_flow  (w_flow),
        .o_valid (w_cur_valid),
        .o_item  (w_cur_item)
    );

    // decode step with the sequence state; state moves only on a step
    ubd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_flow.step),
        .i_item      (w_cur_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    ubd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (w_flow),
        .i_res   (w_res),
        .i_ready (m_tready),
        .o_free  (w_out_free),
        .o_valid (m_tvalid),
        .o_res   (w_out_res)
    );

    // pack the result
    assign m_tdata = {w_out_res.seq_length, w_out_res.code_point};
    assign m_tuser = w_out_res.status;

    // a held byte that cannot advance blocks the input
    `UBD_ASSERT_IMPL(a_stall_blocks_in, w_cur_valid && !w_flow.step, !s_tready)
    // a loaded result is shown on the next cycle
    `UBD_ASSERT_NEXT(a_load_shows, w_flow.load, m_tvalid)
    // a stop carries no code point and no length
    `UBD_ASSERT_IMPL(a_stop_empty, m_tvalid && (m_tuser == ST_STOP),
                     (m_tdata == 24'd0))
    // a replaced sequence always carries the replacement character
    `UBD_ASSERT_IMPL(a_invalid_fffd, m_tvalid && (m_tuser == ST_INVALID),
                     (m_tdata[20:0] == REPLACEMENT_CP) && (m_tdata[23:21] != 3'd0))

endmodule
